/* rtl/core/hrm_pkg.sv */
// ---------------------------------------------------------------------------
// hrm_pkg: shared types and constants for the radiance merge core
// Holds the weight ROM, the field widths and the request struct passed from
// the accumulator to the divider.
// ---------------------------------------------------------------------------
package hrm_pkg;

  localparam int LevelW  = 8;
  localparam int TimeW   = 32;
  localparam int RespW   = 24;
  localparam int SumW    = 64;
  localparam int RadW    = 32;
  localparam int WeightW = 16;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  // Request from the accumulator to the divider
  typedef struct packed {
    logic [SumW-1:0] top;
    logic [SumW-1:0] bottom;
  } hrm_div_req_t;

  // Compute the Q0.16 weight for one level (elaborated into a constant table)
  function automatic logic [WeightW-1:0] weight_q16(input logic [LevelW-1:0] y);
    logic [63:0] d;
    logic [63:0] a;
    logic [63:0] term;
    logic [63:0] r;
    logic [127:0] p;
    if (y == 8'd0 || y == 8'd255) return '0;
    d = (y > 8'd127) ? 64'(2 * y - 255) : 64'(255 - 2 * y);
    a = ((d * d << 32) + 64'd130050) / 64'd260100;
    term = 64'd1 << 32;
    r = term;
    for (int k = 1; k <= 12; k++) begin
      p = 128'(term) * 128'(a);
      term = 64'(p >> 32) / 64'(k);
      if (k % 2 == 1) r = r - term;
      else r = r + term;
    end
    for (int k = 0; k < 4; k++) begin
      p = 128'(r) * 128'(r) + (128'd1 << 31);
      r = 64'(p >> 32);
    end
    r = (r + 64'h8000) >> 16;
    return (r > 64'd65535) ? 16'hFFFF : r[WeightW-1:0];
  endfunction

  // Fill the weight table for every level at elaboration
  function automatic logic [255:0][WeightW-1:0] build_weight_rom();
    logic [255:0][WeightW-1:0] rom;
    for (int y = 0; y < 256; y++) rom[y] = weight_q16(8'(y));
    return rom;
  endfunction

  localparam logic [255:0][WeightW-1:0] WEIGHT_ROM = build_weight_rom();

endpackage

/* rtl/core/hdr_radiance_merge_core.sv */
// ---------------------------------------------------------------------------
// hdr_radiance_merge_core: exposure merge into a Q16.16 radiance estimate
// Response table memory with a sample accumulator, followed by a divider.
// ---------------------------------------------------------------------------
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_stall  | mode channel level exposure_time
//         |           |                      | response_word last
// output  | out       | out_valid / out_stall| radiance no_weight saturated
//
// A load is written in its accepting cycle; a sample takes the accepting
// cycle, then table read and weight, two multiply steps and the add.
// A last sample then waits in S_SEND to hand its sums to the divider, which
// raises out_valid when the division ends (directly for zero or overflow)
// at one quotient bit per cycle; the accumulator waits while a previous
// quotient is still in work or held. Reset clears sums and control;
// the table is undefined until loaded. Stalls hold the result in place.
// ---------------------------------------------------------------------------
module hdr_radiance_merge_core #(
  parameter int Channels = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      mode,
  input  logic [1:0]                channel,
  input  logic [7:0]                level,
  input  logic [31:0]               exposure_time,
  input  logic [23:0]               response_word,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [31:0]               radiance,
  output logic                      no_weight,
  output logic                      saturated
);
  import hrm_pkg::*;

  hrm_div_req_t req;
  logic         req_valid;
  logic         req_stall;

  hrm_accum #(.Channels(Channels)) u_accum (
    .clk, .rst, .in_valid, .in_stall, .mode, .channel, .level,
    .exposure_time, .response_word, .last,
    .req_valid, .req_stall, .req
  );

  hrm_divider u_div (
    .clk, .rst, .req_valid, .req_stall, .req,
    .out_valid, .out_stall, .radiance, .no_weight, .saturated
  );

endmodule

/* rtl/core/hrm_accum.sv */
// ---------------------------------------------------------------------------
// hrm_accum: response table memory and weighted sum accumulation
// Loads write the table; samples read it (registered), then step through
// S_READ, S_WT and S_MULT and add into the sums in S_ADD.
// ---------------------------------------------------------------------------
module hrm_accum #(
  parameter int Channels = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      mode,
  input  logic [1:0]                channel,
  input  logic [hrm_pkg::LevelW-1:0] level,
  input  logic [hrm_pkg::TimeW-1:0] exposure_time,
  input  logic [hrm_pkg::RespW-1:0] response_word,
  input  logic                      last,
  output logic                      req_valid,
  input  logic                      req_stall,
  output hrm_pkg::hrm_div_req_t     req
);
  import hrm_pkg::*;

  localparam int Depth = Channels * 256;
  localparam int AddrW = $clog2(Depth);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_WT   = 6'b000100,
    S_MULT = 6'b001000,
    S_ADD  = 6'b010000,
    S_SEND = 6'b100000
  } state_t;

  state_t state;
  logic [RespW-1:0] table_mem [Depth];
  logic [RespW-1:0] rd_data;
  logic [AddrW-1:0] addr;
  logic             ch_ok;
  logic             ch_ok_q;
  logic             last_q;
  logic [LevelW-1:0] level_q;
  logic [TimeW-1:0] t_q;
  logic [WeightW-1:0] w_q;
  logic [31:0]      wt;
  logic [55:0]      top_inc;
  logic [63:0]      bot_inc;
  logic [SumW-1:0]  top;
  logic [SumW-1:0]  bottom;
  logic [SumW:0]    top_sum;
  logic [SumW:0]    bot_sum;
  logic             accept;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign ch_ok = (32'(channel) < Channels);
  assign addr = AddrW'(32'(channel) * 256 + 32'(level));

  // Table port: write on loads, read once per accepted transfer
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_LOAD && ch_ok) table_mem[addr] <= response_word;
    if (accept && ch_ok) rd_data <= table_mem[addr];
  end

  assign top_sum = {1'b0, top} + {9'b0, top_inc};
  assign bot_sum = {1'b0, bottom} + {1'b0, bot_inc};

  // Sequence one sample through the multiply chain
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      top       <= '0;
      bottom    <= '0;
      req_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && mode == MODE_SAMPLE) begin
            ch_ok_q <= ch_ok;
            last_q  <= last;
            level_q <= level;
            t_q     <= exposure_time;
            state   <= S_READ;
          end
        end
        S_READ: begin
          w_q   <= WEIGHT_ROM[level_q];
          state <= S_WT;
        end
        S_WT: begin
          wt    <= 32'((64'(w_q) * 64'(t_q)) >> 16);
          state <= S_MULT;
        end
        S_MULT: begin
          top_inc <= ch_ok_q ? 56'((72'(wt) * 72'(rd_data)) >> 8) : '0;
          bot_inc <= 64'((80'(wt) * 80'(t_q)) >> 16);
          state   <= S_ADD;
        end
        S_ADD: begin
          if (last_q) begin
            req.top    <= top_sum[SumW] ? '1 : top_sum[SumW-1:0];
            req.bottom <= bot_sum[SumW] ? '1 : bot_sum[SumW-1:0];
            top        <= '0;
            bottom     <= '0;
            req_valid  <= 1'b1;
            state      <= S_SEND;
          end else begin
            top    <= top_sum[SumW] ? '1 : top_sum[SumW-1:0];
            bottom <= bot_sum[SumW] ? '1 : bot_sum[SumW-1:0];
            state  <= S_IDLE;
          end
        end
        S_SEND: begin
          if (!req_stall) begin
            req_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/hrm_divider.sv */
// ---------------------------------------------------------------------------
// hrm_divider: restoring divider for the Q16.16 radiance quotient
// Takes one request, screens zero and overflow, then produces one quotient
// bit per cycle into an output register.
// ---------------------------------------------------------------------------
module hrm_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  hrm_pkg::hrm_div_req_t     req,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [hrm_pkg::RadW-1:0]  radiance,
  output logic                      no_weight,
  output logic                      saturated
);
  import hrm_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_OUT  = 3'b100
  } dstate_t;

  dstate_t state;
  logic [79:0] num;
  logic [SumW-1:0] den;
  logic [SumW:0] rem;
  logic [SumW:0] rem_shift;
  logic [RadW-1:0] quo;
  logic [6:0] count;

  assign req_stall = (state != D_IDLE);
  assign rem_shift = {rem[SumW-1:0], num[79]};

  // Step the division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= D_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        D_IDLE: begin
          if (req_valid) begin
            no_weight <= 1'b0;
            saturated <= 1'b0;
            if (req.bottom == '0) begin
              radiance  <= '0;
              no_weight <= 1'b1;
              out_valid <= 1'b1;
              state     <= D_OUT;
            end else if ((req.top >> 16) >= req.bottom) begin
              radiance  <= '1;
              saturated <= 1'b1;
              out_valid <= 1'b1;
              state     <= D_OUT;
            end else begin
              num   <= {req.top, 16'b0};
              den   <= req.bottom;
              rem   <= '0;
              quo   <= '0;
              count <= 7'd80;
              state <= D_RUN;
            end
          end
        end
        D_RUN: begin
          num <= {num[78:0], 1'b0};
          if (rem_shift >= {1'b0, den}) begin
            rem <= rem_shift - {1'b0, den};
            quo <= {quo[RadW-2:0], 1'b1};
          end else begin
            rem <= rem_shift;
            quo <= {quo[RadW-2:0], 1'b0};
          end
          count <= count - 7'd1;
          if (count == 7'd1) state <= D_OUT;
        end
        D_OUT: begin
          if (!out_valid) begin
            radiance  <= quo;
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/hrm_checker.sv */
// ---------------------------------------------------------------------------
// hrm_checker: port-level checks for the radiance merge core
// Watches result flags and output hold behavior.
// ---------------------------------------------------------------------------
module hrm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] radiance,
  input logic        no_weight,
  input logic        saturated
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(radiance))
    else $error("stalled result changed");

  // Flags never both set
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(no_weight && saturated))
    else $error("both flags set");

  // Zero weight gives zero radiance
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_weight |-> radiance == 32'd0)
    else $error("no_weight with nonzero radiance");

  // Saturation clamps to full scale
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> radiance == 32'hFFFFFFFF)
    else $error("saturated without clamp");

endmodule

bind hdr_radiance_merge_core hrm_checker u_hrm_checker (
  .clk, .rst, .out_valid, .out_stall, .radiance, .no_weight, .saturated
);
